// ===== src/crtc_palette_planar_scanout_defines.svh =====
// assertion macros shared by the scanout block
`ifndef CRTC_PALETTE_PLANAR_SCANOUT_DEFINES_SVH
`define CRTC_PALETTE_PLANAR_SCANOUT_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define CPPS_ASSERT_IMP(name, cond, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define CPPS_ASSERT_NXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== src/cpps_pkg.sv =====
`timescale 1ns / 1ps
package cpps_pkg;

  localparam int NPIX               = 8;
  localparam int CNT_W              = $clog2(NPIX);
  localparam int LA_W               = 17;
  localparam int COLOR_W            = 5;
  localparam int PAL_DEPTH          = 16;
  localparam int PAL_IDX_W          = $clog2(PAL_DEPTH);
  localparam int MODE_DEPTH         = 8;
  localparam int MODE_IDX_W         = $clog2(MODE_DEPTH);
  localparam int VRAM_ADDR_BITS_DEF = 17;
  localparam int LINE_STRIDE_DEF    = 128;

  localparam logic [15:0]        PAL_RESET   = 16'h01ff;
  localparam logic [15:0]        CMD_PALETTE = 16'hffff;
  localparam logic [7:0]         RD_UNMAPPED = 8'hff;
  localparam logic [COLOR_W-1:0] WHITE       = 5'h1f;

  // bus byte offsets
  localparam logic [7:0] ADDR_SEL     = 8'h38;
  localparam logic [7:0] ADDR_MODE    = 8'h3a;
  localparam logic [7:0] ADDR_VSCR_LO = 8'h3c;
  localparam logic [7:0] ADDR_VSCR_HI = 8'h3e;
  localparam logic [7:0] ADDR_PAL_LO  = 8'h40;
  localparam logic [7:0] ADDR_PAL_HI  = 8'h5f;
  localparam logic [7:0] ADDR_CMD_LO  = 8'h60;
  localparam logic [7:0] ADDR_CMD_HI  = 8'h61;

  typedef enum logic [1:0] {
    OP_WR   = 2'd0,
    OP_RD   = 2'd1,
    OP_PIX  = 2'd2,
    OP_LINE = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] offset;
    logic [7:0] wdata;
    logic [7:0] plane0;
    logic [7:0] plane1;
    logic [7:0] plane2;
    logic [7:0] plane3;
    logic [8:0] line;
  } in_t;

  typedef struct packed {
    logic [7:0]         rdata;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [LA_W-1:0]    line_addr;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [PAL_IDX_W-1:0] idx;
    logic                 white;
  } pix_t;

  typedef struct packed {
    logic pixel;
    logic use_pal;
    out_t single;
  } job_t;

  typedef struct packed {
    logic busy;
    logic pix;
    logic fin;
  } job_stat_t;

  // 3-bit palette field to 5-bit intensity
  function automatic logic [COLOR_W-1:0] expand3(input logic [2:0] v);
    return (v == 3'd0) ? '0 : {v, 2'b11};
  endfunction

endpackage

// ===== src/cpps_regs.sv =====
`timescale 1ns / 1ps
module cpps_regs #(
  parameter int VRAM_ADDR_BITS = cpps_pkg::VRAM_ADDR_BITS_DEF,
  parameter int LINE_STRIDE    = cpps_pkg::LINE_STRIDE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [7:0]                     off_i,
  input  logic [7:0]                     wdata_i,
  input  logic [8:0]                     line_i,
  input  logic                           pix_busy_i,
  input  logic [cpps_pkg::PAL_IDX_W-1:0] pix_idx_i,
  output logic [7:0]                     rdata_o,
  output logic [cpps_pkg::LA_W-1:0]      line_addr_o,
  output logic [15:0]                    pal_word_o,
  output logic                           pal_mode_o
);
  import cpps_pkg::*;

  localparam logic [31:0]        ADDR_MASK = 32'((64'(1) << VRAM_ADDR_BITS) - 64'(1));
  localparam logic signed [31:0] STRIDE_S  = 32'(LINE_STRIDE);

  logic [7:0]  sel_q;
  logic [7:0]  mode_q [MODE_DEPTH];
  logic [15:0] vscroll_q;
  logic [15:0] cmd_q;
  logic [15:0] pal_q  [PAL_DEPTH];

  logic [PAL_IDX_W-1:0] pal_addr;
  logic signed [8:0]    h_sum;
  logic signed [11:0]   v_sum;
  logic signed [31:0]   start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q     <= '0;
      vscroll_q <= '0;
      cmd_q     <= '0;
      for (int i = 0; i < MODE_DEPTH; i++) begin
        mode_q[i] <= '0;
      end
      pal_q[0] <= '0;
      for (int i = 1; i < PAL_DEPTH; i++) begin
        pal_q[i] <= PAL_RESET;
      end
    end else if (wr_en_i) begin
      unique case (off_i) inside
        ADDR_SEL:     sel_q <= wdata_i;
        ADDR_MODE:    mode_q[sel_q[MODE_IDX_W-1:0]] <= wdata_i;
        ADDR_VSCR_LO: vscroll_q[7:0] <= wdata_i;
        ADDR_VSCR_HI: vscroll_q[15:8] <= wdata_i;
        [ADDR_PAL_LO:ADDR_PAL_HI]: begin
          if (off_i[0]) begin
            pal_q[off_i[PAL_IDX_W:1]][15:8] <= wdata_i;
          end else begin
            pal_q[off_i[PAL_IDX_W:1]][7:0] <= wdata_i;
          end
        end
        ADDR_CMD_LO:  cmd_q[7:0] <= wdata_i;
        ADDR_CMD_HI:  cmd_q[15:8] <= wdata_i;
        default: ;
      endcase
    end
  end

  // single palette read port, owned by the pixel serializer while a group is out
  assign pal_addr   = pix_busy_i ? pix_idx_i : off_i[PAL_IDX_W:1];
  assign pal_word_o = pal_q[pal_addr];
  assign pal_mode_o = (cmd_q == CMD_PALETTE);

  always_comb begin
    unique case (off_i) inside
      ADDR_SEL:                  rdata_o = sel_q;
      ADDR_MODE:                 rdata_o = mode_q[sel_q[MODE_IDX_W-1:0]];
      ADDR_VSCR_LO:              rdata_o = vscroll_q[7:0];
      ADDR_VSCR_HI:              rdata_o = vscroll_q[15:8];
      [ADDR_PAL_LO:ADDR_PAL_HI]: rdata_o = off_i[0] ? pal_word_o[15:8] : pal_word_o[7:0];
      ADDR_CMD_LO:               rdata_o = cmd_q[7:0];
      ADDR_CMD_HI:               rdata_o = cmd_q[15:8];
      default:                   rdata_o = RD_UNMAPPED;
    endcase
  end

  // signed horizontal and vertical offsets
  assign h_sum = 9'(signed'(mode_q[0][6:0])) + 9'(signed'({1'b0, mode_q[2][6:1]}))
               + 9'sd1;
  assign v_sum = 12'(signed'(vscroll_q[10:0])) + 12'(signed'({1'b0, mode_q[6][6:1]}))
               + 12'(signed'({1'b0, line_i}));
  assign start = (32'(h_sum) <<< 1) + 32'(v_sum) * STRIDE_S;

  assign line_addr_o = LA_W'(start & ADDR_MASK);

endmodule

// ===== src/cpps_lane.sv =====
`timescale 1ns / 1ps
module cpps_lane (
  input  logic                           clk_i,
  input  logic                           load_i,
  input  logic [cpps_pkg::PAL_IDX_W-1:0] bits_i,
  output cpps_pkg::pix_t                 pix_o
);
  import cpps_pkg::*;

  logic [PAL_IDX_W-1:0] bits_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bits_q <= bits_i;
    end
  end

  // plane 0 alone decides the mono color
  assign pix_o.idx   = bits_q;
  assign pix_o.white = bits_q[0];

endmodule

// ===== src/cpps_merge.sv =====
`timescale 1ns / 1ps
module cpps_merge (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  cpps_pkg::job_t                 job_i,
  input  cpps_pkg::pix_t                 pix_i [cpps_pkg::NPIX],
  input  logic [15:0]                    pal_word_i,
  input  logic                           out_ready_i,
  output cpps_pkg::job_stat_t            stat_o,
  output logic [cpps_pkg::PAL_IDX_W-1:0] pix_idx_o,
  output logic                           out_valid_o,
  output cpps_pkg::out_t                 out_o
);
  import cpps_pkg::*;

  logic             job_valid_q;
  job_t             job_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  out_t             out_q;

  pix_t cur;
  logic can_emit;
  logic last_pix;
  out_t res;

  assign cur       = pix_i[cnt_q];
  assign pix_idx_o = cur.idx;
  assign can_emit  = job_valid_q && (!out_valid_q || out_ready_i);
  assign last_pix  = (cnt_q == CNT_W'(NPIX - 1));

  assign stat_o.busy = job_valid_q;
  assign stat_o.pix  = job_valid_q && job_q.pixel;
  assign stat_o.fin  = can_emit && (!job_q.pixel || last_pix);

  always_comb begin
    res = '0;
    if (job_q.pixel) begin
      if (job_q.use_pal) begin
        res.red   = expand3(pal_word_i[2:0]);
        res.green = expand3(pal_word_i[5:3]);
        res.blue  = expand3(pal_word_i[8:6]);
      end else if (cur.white) begin
        res.red   = WHITE;
        res.green = WHITE;
        res.blue  = WHITE;
      end
      res.last = last_pix;
    end else begin
      res = job_q.single;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        job_valid_q <= 1'b1;
      end else if (stat_o.fin) begin
        job_valid_q <= 1'b0;
      end
      if (load_i) begin
        cnt_q <= '0;
      end else if (can_emit && job_q.pixel) begin
        cnt_q <= CNT_W'(cnt_q + 1'b1);
      end
      if (can_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      job_q <= job_i;
    end
    if (can_emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== src/crtc_palette_planar_scanout.sv =====
`timescale 1ns / 1ps
// Bit-plane scanout with a byte register bus, one valid/ready input channel
// carrying bus writes, bus reads, pixel groups and line address queries, and
// one valid/ready result channel.
// A bus write updates the registers at acceptance and gives no result.
// A bus read or line query is latched into the merge stage at acceptance and
// gives one result through the result register; one such item can be taken
// every cycle while the receiver does not stall. A pixel group is latched
// into eight pixel lanes at acceptance; the merge stage then hands out one
// pixel per cycle while the result side is not stalled. The next item is
// taken in the cycle the last pixel of a group leaves the lanes.
// The merge stage shares the single palette read port with bus reads, so a
// bus read waits until a pixel group has been fully handed out, and a bus
// write waits for the last lookup of the group in progress.
// Reset clears all registers to their defaults at once; no init pass.
// When the receiver stalls, the result register holds and the lanes hold
// their group; save bus writes outside a group, input waits for the result side.
module crtc_palette_planar_scanout #(
  parameter int VRAM_ADDR_BITS = cpps_pkg::VRAM_ADDR_BITS_DEF,
  parameter int LINE_STRIDE    = cpps_pkg::LINE_STRIDE_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cpps_pkg::in_t   in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cpps_pkg::out_t  out_o
);
  import cpps_pkg::*;

  `include "crtc_palette_planar_scanout_defines.svh"

  job_stat_t            job_stat;
  logic                 accept;
  logic                 wr_en;
  logic                 load;
  logic                 pix_load;
  logic [7:0]           rdata;
  logic [LA_W-1:0]      line_addr;
  logic [15:0]          pal_word;
  logic                 pal_mode;
  logic [PAL_IDX_W-1:0] pix_idx;
  job_t                 job;
  pix_t                 pix [NPIX];

  always_comb begin
    case (in_i.op)
      OP_WR:   in_ready_o = !job_stat.pix || job_stat.fin;
      OP_RD:   in_ready_o = !job_stat.busy || (job_stat.fin && !job_stat.pix);
      default: in_ready_o = !job_stat.busy || job_stat.fin;
    endcase
  end

  assign accept   = in_valid_i && in_ready_o;
  assign wr_en    = accept && (in_i.op == OP_WR);
  assign load     = accept && (in_i.op != OP_WR);
  assign pix_load = accept && (in_i.op == OP_PIX);

  cpps_regs #(
    .VRAM_ADDR_BITS (VRAM_ADDR_BITS),
    .LINE_STRIDE    (LINE_STRIDE)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .off_i       (in_i.offset),
    .wdata_i     (in_i.wdata),
    .line_i      (in_i.line),
    .pix_busy_i  (job_stat.pix),
    .pix_idx_i   (pix_idx),
    .rdata_o     (rdata),
    .line_addr_o (line_addr),
    .pal_word_o  (pal_word),
    .pal_mode_o  (pal_mode)
  );

  for (genvar k = 0; k < NPIX; k++) begin : g_lane
    cpps_lane u_lane (
      .clk_i  (clk_i),
      .load_i (pix_load),
      .bits_i ({in_i.plane3[k], in_i.plane2[k], in_i.plane1[k], in_i.plane0[k]}),
      .pix_o  (pix[k])
    );
  end

  always_comb begin
    job                  = '0;
    job.pixel            = (in_i.op == OP_PIX);
    job.use_pal          = pal_mode;
    job.single.last      = 1'b1;
    job.single.rdata     = (in_i.op == OP_RD) ? rdata : '0;
    job.single.line_addr = (in_i.op == OP_LINE) ? line_addr : '0;
  end

  cpps_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .job_i       (job),
    .pix_i       (pix),
    .pal_word_i  (pal_word),
    .out_ready_i (out_ready_i),
    .stat_o      (job_stat),
    .pix_idx_o   (pix_idx),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

  `CPPS_ASSERT_IMP(a_mid_group, out_valid_o && !out_o.last, job_stat.pix,
                   "non-final result while no pixel group is in progress")
  `CPPS_ASSERT_NXT(a_group_end, job_stat.fin && job_stat.pix, out_valid_o && out_o.last,
                   "end of pixel group did not show a final result")
  `CPPS_ASSERT_NXT(a_pal_hold, job_stat.pix && !job_stat.fin, $stable(pal_mode),
                   "color mode changed inside a pixel group")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import cpps_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_o;

  crtc_palette_planar_scanout dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  // shadow copy of the register file
  logic [7:0]  sel_latch;
  logic [7:0]  mode_reg [MODE_DEPTH];
  logic [15:0] vscroll;
  logic [15:0] cmd_word;
  logic [15:0] pal_word [PAL_DEPTH];

  out_t pending_pixels[$];
  int   mismatch_cnt;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_left;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [COLOR_W-1:0] widen3(logic [2:0] v);
    return (v == 3'd0) ? '0 : COLOR_W'(v * 4 + 3);
  endfunction

  function automatic logic [7:0] reg_byte(logic [7:0] off);
    logic [15:0] w;
    if (off == ADDR_SEL) return sel_latch;
    if (off == ADDR_MODE) return mode_reg[sel_latch[MODE_IDX_W-1:0]];
    if (off == ADDR_VSCR_LO) return vscroll[7:0];
    if (off == ADDR_VSCR_HI) return vscroll[15:8];
    if (off >= ADDR_PAL_LO && off <= ADDR_PAL_HI) begin
      w = pal_word[off[4:1]];
      return off[0] ? w[15:8] : w[7:0];
    end
    if (off == ADDR_CMD_LO) return cmd_word[7:0];
    if (off == ADDR_CMD_HI) return cmd_word[15:8];
    return RD_UNMAPPED;
  endfunction

  function automatic void reg_write(logic [7:0] off, logic [7:0] d);
    if (off == ADDR_SEL) sel_latch = d;
    else if (off == ADDR_MODE) mode_reg[sel_latch[MODE_IDX_W-1:0]] = d;
    else if (off == ADDR_VSCR_LO) vscroll[7:0] = d;
    else if (off == ADDR_VSCR_HI) vscroll[15:8] = d;
    else if (off >= ADDR_PAL_LO && off <= ADDR_PAL_HI) begin
      if (off[0]) pal_word[off[4:1]][15:8] = d;
      else pal_word[off[4:1]][7:0] = d;
    end
    else if (off == ADDR_CMD_LO) cmd_word[7:0] = d;
    else if (off == ADDR_CMD_HI) cmd_word[15:8] = d;
  endfunction

  // start address from signed scroll and offset registers
  function automatic logic [LA_W-1:0] line_start(logic [8:0] ln);
    int hs, hd, vd, vs, sa;
    hs = int'($signed(mode_reg[0][6:0]));
    hd = int'(mode_reg[2][6:1]);
    vd = int'(mode_reg[6][6:1]);
    vs = int'($signed(vscroll[10:0]));
    sa = (hs + hd + 1) * 2 + (vs + vd + int'(ln)) * LINE_STRIDE_DEF;
    return sa[LA_W-1:0];
  endfunction

  function automatic void predict_scanout(in_t it);
    out_t r;
    logic [PAL_IDX_W-1:0] idx;
    logic [15:0] w;
    r = '0;
    r.last = 1'b1;
    case (op_e'(it.op))
      OP_WR: reg_write(it.offset, it.wdata);
      OP_RD: begin
        r.rdata = reg_byte(it.offset);
        pending_pixels.push_back(r);
      end
      OP_LINE: begin
        r.line_addr = line_start(it.line);
        pending_pixels.push_back(r);
      end
      OP_PIX: begin
        for (int k = 0; k < NPIX; k++) begin
          r = '0;
          r.last = (k == NPIX - 1);
          if (cmd_word == CMD_PALETTE) begin
            idx = {it.plane3[k], it.plane2[k], it.plane1[k], it.plane0[k]};
            w = pal_word[idx];
            r.red   = widen3(w[2:0]);
            r.green = widen3(w[5:3]);
            r.blue  = widen3(w[8:6]);
          end else if (it.plane0[k]) begin
            r.red   = WHITE;
            r.green = WHITE;
            r.blue  = WHITE;
          end
          pending_pixels.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("tb: mismatch %s got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
    mismatch_cnt++;
  endtask

  // predict on every accepted input item
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) predict_scanout(in_i);
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected item", out_o, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_o.rdata !== want.rdata) report_mismatch("rdata", out_o.rdata, want.rdata);
        if (out_o.red !== want.red) report_mismatch("red", out_o.red, want.red);
        if (out_o.green !== want.green) report_mismatch("green", out_o.green, want.green);
        if (out_o.blue !== want.blue) report_mismatch("blue", out_o.blue, want.blue);
        if (out_o.line_addr !== want.line_addr) begin
          report_mismatch("line_addr", out_o.line_addr, want.line_addr);
        end
        if (out_o.last !== want.last) report_mismatch("last", out_o.last, want.last);
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send(in_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= it;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic in_t noise();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[$bits(in_t)-1:0];
  endfunction

  function automatic in_t mk_wr(logic [7:0] off, logic [7:0] d);
    in_t it;
    it = noise();
    it.op = OP_WR;
    it.offset = off;
    it.wdata = d;
    return it;
  endfunction

  function automatic in_t mk_rd(logic [7:0] off);
    in_t it;
    it = noise();
    it.op = OP_RD;
    it.offset = off;
    return it;
  endfunction

  function automatic in_t mk_pix(logic [7:0] p0, logic [7:0] p1, logic [7:0] p2,
                                 logic [7:0] p3);
    in_t it;
    it = noise();
    it.op = OP_PIX;
    it.plane0 = p0;
    it.plane1 = p1;
    it.plane2 = p2;
    it.plane3 = p3;
    return it;
  endfunction

  function automatic in_t mk_line(logic [8:0] ln);
    in_t it;
    it = noise();
    it.op = OP_LINE;
    it.line = ln;
    return it;
  endfunction

  // mostly mapped offsets; command writes lean toward enabling the palette
  function automatic in_t random_item();
    in_t it;
    it = noise();
    if ($urandom_range(3) != 0) begin
      case ($urandom_range(6))
        0: it.offset = ADDR_SEL;
        1: it.offset = ADDR_MODE;
        2: it.offset = ADDR_VSCR_LO;
        3: it.offset = ADDR_VSCR_HI;
        4: it.offset = ADDR_CMD_LO + 8'($urandom_range(1));
        default: it.offset = 8'($urandom_range(ADDR_PAL_LO, ADDR_PAL_HI));
      endcase
    end
    if (op_e'(it.op) == OP_WR && (it.offset == ADDR_CMD_LO || it.offset == ADDR_CMD_HI)
        && $urandom_range(9) < 7) begin
      it.wdata = 8'hff;
    end
    return it;
  endfunction

  task automatic test_reset_defaults();
    send(mk_rd(ADDR_SEL));
    send(mk_rd(ADDR_MODE));
    send(mk_rd(ADDR_VSCR_LO));
    send(mk_rd(ADDR_VSCR_HI));
    send(mk_rd(ADDR_PAL_LO));
    send(mk_rd(ADDR_PAL_LO + 8'd3));
    send(mk_rd(ADDR_PAL_HI));
    send(mk_rd(ADDR_CMD_HI));
    send(mk_rd(8'hff));
    send(mk_rd(8'h00));
    send(mk_pix(8'ha5, 8'hff, 8'hff, 8'hff));
  endtask

  task automatic test_line_address();
    send(mk_wr(ADDR_SEL, 8'h00));
    send(mk_wr(ADDR_MODE, 8'h40));   // most negative horizontal scroll
    send(mk_wr(ADDR_SEL, 8'h02));
    send(mk_wr(ADDR_MODE, 8'h7e));
    send(mk_wr(ADDR_SEL, 8'hfe));    // selects mode register 6
    send(mk_wr(ADDR_MODE, 8'hfe));
    send(mk_wr(ADDR_VSCR_HI, 8'hfc)); // most negative vertical scroll
    send(mk_wr(ADDR_VSCR_LO, 8'h00));
    send(mk_line(9'd0));
    send(mk_line(9'd511));
  endtask

  task automatic test_palette_lookup();
    send(mk_wr(ADDR_CMD_LO, 8'hff));
    send(mk_wr(ADDR_CMD_HI, 8'hff));
    send(mk_wr(ADDR_PAL_HI - 8'd1, 8'hc7));
    send(mk_pix(8'h55, 8'h33, 8'h0f, 8'h00));
    send(mk_pix(8'hff, 8'hff, 8'hff, 8'hff));
    send(mk_rd(ADDR_PAL_HI - 8'd1));
  endtask

  // receiver holds off while the sender keeps offering pixel groups
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 200;
    repeat (6) send(mk_pix(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
    send(mk_rd(ADDR_CMD_LO));
    send(mk_line(9'($urandom)));
    send(mk_pix(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
  endtask

  task automatic test_random_traffic(int n, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send(random_item());
  endtask

  initial begin
    int i;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_i           = '0;
    mismatch_cnt   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    sel_latch      = '0;
    vscroll        = '0;
    cmd_word       = '0;
    for (i = 0; i < MODE_DEPTH; i++) mode_reg[i] = '0;
    pal_word[0] = '0;
    for (i = 1; i < PAL_DEPTH; i++) pal_word[i] = PAL_RESET;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_line_address();
    test_palette_lookup();
    test_backpressure();
    test_random_traffic(54, 0, 0);
    test_random_traffic(54, 72, 0);
    test_random_traffic(54, 0, 72);
    test_random_traffic(54, 34, 34);

    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== crtc_palette_planar_scanout.f =====
+incdir+src
src/cpps_pkg.sv
src/cpps_regs.sv
src/cpps_lane.sv
src/cpps_merge.sv
src/crtc_palette_planar_scanout.sv
tb/sv/tb.sv
